/* rtl/core/sorted_top_k_list_unit_defines.svh */
// Assertion macros shared by the sorted top-K list unit.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SORTED_TOP_K_LIST_UNIT_DEFINES_SVH
`define SORTED_TOP_K_LIST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STKL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted top-K list check failed");

// The consequent must hold in the cycle after the antecedent.
`define STKL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted top-K list check failed");

`endif

/* rtl/core/stkl_pkg.sv */
// Package for the sorted top-K list unit: sizes, entry type, command and cell codes.
// Has no dependencies; used by stkl_cell and sorted_top_k_list_unit.
package stkl_pkg;

    localparam int unsigned DEPTH   = 64;
    localparam int unsigned LEN_W   = $clog2(DEPTH + 1);
    localparam int unsigned TAG_W   = 32;
    localparam int unsigned SCORE_W = 32;

    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(DEPTH);
    localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W - 1){1'b0}}};

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD_NEW,
        OP_FROM_PREV,
        OP_FROM_NEXT,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        logic               filled;
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] score;
    } t_entry;

    localparam t_entry EMPTY_ENTRY = '{filled: 1'b0, tag: '0, score: SCORE_MIN};

endpackage

/* rtl/core/sorted_top_k_list_unit.sv */
// Sorted top-K list unit: a chain of stkl_cell slots kept in descending score order.
// Depends on stkl_pkg, stkl_cell and sorted_top_k_list_unit_defines.svh.
//
// Usage. Requests arrive on i_in_valid / o_in_ready with i_command, i_item_id and
// i_item_score. An insert is placed after every active entry of equal or higher
// score if its score is not below the last active entry; the tail entry drops out.
// A pop returns the head entry and shifts the others up, refilling the tail slot.
// Each request gives one result on o_out_valid / i_out_ready.
// The list length comes from i_cfg_data when i_cfg_we is high; 0 acts as 1 and
// values above the depth act as the depth. Write it only while the unit is idle.
// The result is registered at the edge that takes the request. Throughput is one
// request per cycle unless a held result stalls the input; every slot compares
// against the new score and moves in the same cycle, so the cell chain sets the rate.
// A held result stalls the input only while i_out_ready is low; the output
// register parts the two sides. Reset empties all slots and sets the length to 64.
`include "sorted_top_k_list_unit_defines.svh"

module sorted_top_k_list_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [stkl_pkg::LEN_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_command,
    input  logic [stkl_pkg::TAG_W-1:0]       i_item_id,
    input  logic signed [stkl_pkg::SCORE_W-1:0] i_item_score,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_accepted,
    output logic                             o_popped_valid,
    output logic [stkl_pkg::TAG_W-1:0]       o_popped_id,
    output logic signed [stkl_pkg::SCORE_W-1:0] o_popped_score,
    output logic                             o_head_valid
);

    localparam int unsigned DEPTH = stkl_pkg::DEPTH;
    localparam int unsigned LEN_W = stkl_pkg::LEN_W;

    logic [LEN_W-1:0] r_list_length;
    logic [LEN_W-1:0] w_len;

    logic r_out_valid;
    logic r_accepted;
    logic r_popped_valid;
    logic [stkl_pkg::TAG_W-1:0] r_popped_id;
    logic signed [stkl_pkg::SCORE_W-1:0] r_popped_score;
    logic r_head_valid;

    stkl_pkg::t_entry   w_new;
    stkl_pkg::t_entry   w_entry   [DEPTH];
    stkl_pkg::t_entry   w_prev_in [DEPTH];
    stkl_pkg::t_entry   w_next_in [DEPTH];
    stkl_pkg::t_cell_op w_op      [DEPTH];

    logic [DEPTH-1:0] w_ge;
    logic [DEPTH-1:0] w_ge_mask;
    logic [DEPTH-1:0] w_keep;
    logic [DEPTH-1:0] w_is_pos;
    logic [DEPTH-1:0] w_active;
    logic [DEPTH-1:0] w_last;

    logic [stkl_pkg::SCORE_W-1:0] w_tail_score;

    logic w_in_fire;
    logic w_fits;
    logic w_ins;
    logic w_pop;
    logic w_head_next;

    always_comb begin
        priority if (r_list_length == '0) begin
            w_len = LEN_W'(1);
        end else if (r_list_length > LEN_W'(DEPTH)) begin
            w_len = LEN_W'(DEPTH);
        end else begin
            w_len = r_list_length;
        end
    end

    assign w_new = '{filled: 1'b1, tag: i_item_id, score: i_item_score};

    always_comb begin
        w_tail_score = stkl_pkg::SCORE_MIN;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_last[k]) begin
                w_tail_score = w_entry[k].score;
            end
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_fits     = $signed(i_item_score) >= $signed(w_tail_score);
    assign w_ins      = w_in_fire && (stkl_pkg::t_command'(i_command) == stkl_pkg::CMD_INSERT)
                        && w_fits;
    assign w_pop      = w_in_fire && (stkl_pkg::t_command'(i_command) == stkl_pkg::CMD_POP);

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign w_active[k]  = LEN_W'(k) < w_len;
        assign w_last[k]    = LEN_W'(k) == (w_len - LEN_W'(1));
        assign w_ge_mask[k] = w_ge[k] && (LEN_W'(k + 1) < w_len);
        assign w_keep[k]    = |(w_ge_mask >> k);

        if (k == 0) begin : g_head
            assign w_prev_in[k] = stkl_pkg::EMPTY_ENTRY;
            assign w_is_pos[k]  = !w_keep[k];
        end else begin : g_body
            assign w_prev_in[k] = w_entry[k-1];
            assign w_is_pos[k]  = !w_keep[k] && w_keep[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign w_next_in[k] = stkl_pkg::EMPTY_ENTRY;
        end else begin : g_inner
            assign w_next_in[k] = w_entry[k+1];
        end

        always_comb begin
            priority if (!w_active[k]) begin
                w_op[k] = stkl_pkg::OP_HOLD;
            end else if (w_ins) begin
                priority if (w_keep[k]) begin
                    w_op[k] = stkl_pkg::OP_HOLD;
                end else if (w_is_pos[k]) begin
                    w_op[k] = stkl_pkg::OP_LOAD_NEW;
                end else begin
                    w_op[k] = stkl_pkg::OP_FROM_PREV;
                end
            end else if (w_pop) begin
                w_op[k] = w_last[k] ? stkl_pkg::OP_CLEAR : stkl_pkg::OP_FROM_NEXT;
            end else begin
                w_op[k] = stkl_pkg::OP_HOLD;
            end
        end

        stkl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op[k]),
            .i_new   (w_new),
            .i_prev  (w_prev_in[k]),
            .i_next  (w_next_in[k]),
            .o_entry (w_entry[k]),
            .o_ge    (w_ge[k])
        );
    end

    always_comb begin
        priority if (w_pop) begin
            w_head_next = w_last[0] ? 1'b0 : w_next_in[0].filled;
        end else if (w_ins) begin
            w_head_next = w_keep[0] ? w_entry[0].filled : 1'b1;
        end else begin
            w_head_next = w_entry[0].filled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_length <= stkl_pkg::LEN_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_list_length <= i_cfg_data;
            end
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_accepted     <= w_ins;
            r_popped_valid <= w_pop && w_entry[0].filled;
            r_popped_id    <= w_pop ? w_entry[0].tag : '0;
            r_popped_score <= w_pop ? $signed(w_entry[0].score) : '0;
            r_head_valid   <= w_head_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_popped_valid = r_popped_valid;
    assign o_popped_id    = r_popped_id;
    assign o_popped_score = r_popped_score;
    assign o_head_valid   = r_head_valid;

    `STKL_ASSERT_NEXT(a_result_follows, w_in_fire, r_out_valid)
    `STKL_ASSERT_SAME(a_one_kind, r_out_valid, !(r_accepted && r_popped_valid))
    `STKL_ASSERT_SAME(a_head_matches_cell, r_out_valid, r_head_valid == w_entry[0].filled)

endmodule

/* rtl/core/stkl_cell.sv */
// One slot of the sorted list: holds an entry and loads it from a neighbour,
// from the new request, or from the empty value. Depends on stkl_pkg.
module stkl_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stkl_pkg::t_cell_op i_op,
    input  stkl_pkg::t_entry  i_new,
    input  stkl_pkg::t_entry  i_prev,
    input  stkl_pkg::t_entry  i_next,
    output stkl_pkg::t_entry  o_entry,
    output logic              o_ge
);

    stkl_pkg::t_entry r_entry;
    stkl_pkg::t_entry n_entry;

    always_comb begin
        unique case (i_op)
            stkl_pkg::OP_HOLD:      n_entry = r_entry;
            stkl_pkg::OP_LOAD_NEW:  n_entry = i_new;
            stkl_pkg::OP_FROM_PREV: n_entry = i_prev;
            stkl_pkg::OP_FROM_NEXT: n_entry = i_next;
            stkl_pkg::OP_CLEAR:     n_entry = stkl_pkg::EMPTY_ENTRY;
            default:                n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= stkl_pkg::EMPTY_ENTRY;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_ge    = $signed(r_entry.score) >= $signed(i_new.score);

endmodule

/* tb/sv/tb_sorted_top_k_list_unit.sv */
// Self-checking testbench for sorted_top_k_list_unit: a scoreboard class predicts every result.
// It drives insert and pop requests with random gaps and output stalls over several list lengths.
// Depends on stkl_pkg and the RTL of sorted_top_k_list_unit.
`timescale 1ns / 100ps

module tb_sorted_top_k_list_unit;

    localparam int unsigned LEN_W = stkl_pkg::LEN_W;

    typedef struct {
        logic                         accepted;
        logic                         popped_valid;
        logic [stkl_pkg::TAG_W-1:0]   popped_id;
        logic [stkl_pkg::SCORE_W-1:0] popped_score;
        logic                         head_valid;
    } t_outcome;

    class topk_scoreboard;
        logic [stkl_pkg::TAG_W-1:0]          tags [stkl_pkg::DEPTH];
        logic signed [stkl_pkg::SCORE_W-1:0] scores [stkl_pkg::DEPTH];
        bit                                  filled [stkl_pkg::DEPTH];
        logic [stkl_pkg::LEN_W-1:0]          length_reg;
        t_outcome                            outcome_q [$];
        int                                  failures;

        function new();
            for (int k = 0; k < stkl_pkg::DEPTH; k++) begin
                tags[k] = '0;
                scores[k] = stkl_pkg::SCORE_MIN;
                filled[k] = 1'b0;
            end
            length_reg = stkl_pkg::LEN_RESET;
            failures = 0;
        endfunction

        function void set_length(input logic [stkl_pkg::LEN_W-1:0] value);
            length_reg = value;
        endfunction

        function int outstanding();
            return outcome_q.size();
        endfunction

        function void note_request(input stkl_pkg::t_command cmd,
                                   input logic [stkl_pkg::TAG_W-1:0] id,
                                   input logic signed [stkl_pkg::SCORE_W-1:0] score);
            int       n;
            int       pos;
            t_outcome res;
            n = int'(length_reg);
            if (n < 1) n = 1;
            if (n > stkl_pkg::DEPTH) n = stkl_pkg::DEPTH;
            res = '{default: '0};
            if (cmd == stkl_pkg::CMD_INSERT) begin
                if (score >= scores[n-1]) begin
                    pos = n - 1;
                    while (pos > 0 && scores[pos-1] < score) pos--;
                    for (int k = n - 1; k > pos; k--) begin
                        tags[k] = tags[k-1];
                        scores[k] = scores[k-1];
                        filled[k] = filled[k-1];
                    end
                    tags[pos] = id;
                    scores[pos] = score;
                    filled[pos] = 1'b1;
                    res.accepted = 1'b1;
                end
            end else begin
                res.popped_valid = filled[0];
                res.popped_id = tags[0];
                res.popped_score = scores[0];
                for (int k = 0; k + 1 < n; k++) begin
                    tags[k] = tags[k+1];
                    scores[k] = scores[k+1];
                    filled[k] = filled[k+1];
                end
                tags[n-1] = '0;
                scores[n-1] = stkl_pkg::SCORE_MIN;
                filled[n-1] = 1'b0;
            end
            res.head_valid = filled[0];
            outcome_q = {outcome_q, res};
        endfunction

        function void compare_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
                failures++;
            end
        endfunction

        function void check_result(input t_outcome act);
            t_outcome exp_r;
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h %h %h %h %h", $time,
                         act.accepted, act.popped_valid, act.popped_id, act.popped_score,
                         act.head_valid);
                failures++;
            end else begin
                exp_r = outcome_q.pop_front();
                compare_field("accepted", 32'(exp_r.accepted), 32'(act.accepted));
                compare_field("popped_valid", 32'(exp_r.popped_valid), 32'(act.popped_valid));
                compare_field("popped_id", exp_r.popped_id, act.popped_id);
                compare_field("popped_score", exp_r.popped_score, act.popped_score);
                compare_field("head_valid", 32'(exp_r.head_valid), 32'(act.head_valid));
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [stkl_pkg::LEN_W-1:0]          i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic                                i_command = 1'b0;
    logic [stkl_pkg::TAG_W-1:0]          i_item_id = '0;
    logic signed [stkl_pkg::SCORE_W-1:0] i_item_score = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic                                o_accepted;
    logic                                o_popped_valid;
    logic [stkl_pkg::TAG_W-1:0]          o_popped_id;
    logic signed [stkl_pkg::SCORE_W-1:0] o_popped_score;
    logic                                o_head_valid;

    topk_scoreboard sb;
    bit             gaps_on = 1'b1;

    sorted_top_k_list_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_item_id      (i_item_id),
        .i_item_score   (i_item_score),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_accepted     (o_accepted),
        .o_popped_valid (o_popped_valid),
        .o_popped_id    (o_popped_id),
        .o_popped_score (o_popped_score),
        .o_head_valid   (o_head_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result('{accepted: o_accepted, popped_valid: o_popped_valid,
                                  popped_id: o_popped_id, popped_score: o_popped_score,
                                  head_valid: o_head_valid});
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_request(stkl_pkg::t_command'(i_command), i_item_id, i_item_score);
            end
        end
    end

    task automatic send_request(input stkl_pkg::t_command cmd,
                                input logic [stkl_pkg::TAG_W-1:0] id,
                                input logic signed [stkl_pkg::SCORE_W-1:0] score);
        while (gaps_on && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_item_id <= id;
        i_item_score <= score;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [stkl_pkg::LEN_W-1:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_length(value);
    endtask

    function automatic logic signed [stkl_pkg::SCORE_W-1:0] random_score();
        unique case ($urandom_range(9))
            0: return stkl_pkg::SCORE_MIN;
            1: return 32'sh7FFF_FFFF;
            2, 3, 4: return 32'($urandom_range(16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int count, input int insert_pct);
        stkl_pkg::t_command cmd;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(99) < insert_pct) ? stkl_pkg::CMD_INSERT : stkl_pkg::CMD_POP;
            send_request(cmd, $urandom, random_score());
        end
    endtask

    initial begin
        int lengths [11];
        sb = new();
        lengths = '{64, 1, 0, 2, 127, 65, 5, 16, 64, 0, 3};
        lengths[9] = $urandom_range(1, 64);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset length: empty head, extremes and ties.
        send_request(stkl_pkg::CMD_POP, 32'h0, 32'sh0);
        send_request(stkl_pkg::CMD_INSERT, 32'h0000_1111, stkl_pkg::SCORE_MIN);
        send_request(stkl_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_request(stkl_pkg::CMD_INSERT, 32'h0, 32'sh0);
        send_request(stkl_pkg::CMD_INSERT, 32'h0000_000A, 32'sd5);
        send_request(stkl_pkg::CMD_INSERT, 32'h0000_000B, 32'sd5);
        send_request(stkl_pkg::CMD_INSERT, 32'h0000_000C, -32'sd1);
        send_request(stkl_pkg::CMD_INSERT, 32'h0000_000D, 32'sd5);
        repeat (8) send_request(stkl_pkg::CMD_POP, $urandom, $urandom);

        // A single-entry list: rejection, equal-score replacement and minimum-score fill.
        write_length(7'd1);
        send_request(stkl_pkg::CMD_INSERT, 32'h0000_0001, 32'sd10);
        send_request(stkl_pkg::CMD_INSERT, 32'h0000_0002, 32'sd3);
        send_request(stkl_pkg::CMD_INSERT, 32'h0000_0003, 32'sd10);
        send_request(stkl_pkg::CMD_POP, 32'h0, 32'sh0);
        send_request(stkl_pkg::CMD_POP, 32'h0, 32'sh0);
        send_request(stkl_pkg::CMD_INSERT, 32'h5555_AAAA, stkl_pkg::SCORE_MIN);
        send_request(stkl_pkg::CMD_POP, 32'h0, 32'sh0);

        for (int p = 0; p < 11; p++) begin
            write_length(LEN_W'(lengths[p]));
            gaps_on = (p != 8);
            run_phase(105, (lengths[p] == 64) ? 75 : $urandom_range(45, 85));
        end

        drain_results();
        if (sb.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
